@@ rtl/core/icr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icr_pkg
// Shared types and constants for the icon contrast remap unit.
// ----------------------------------------------------------------------------
package icr_pkg;

	// configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] CFG_RANGE_WIDTH   = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_CENTER_LEVEL  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_ALPHA_PRESENT = 2'd2;

	// configuration reset values
	localparam logic [7:0] RANGE_WIDTH_RST   = 8'd0;
	localparam logic [7:0] CENTER_LEVEL_RST  = 8'd128;
	localparam logic       ALPHA_PRESENT_RST = 1'b1;

	// statistics reset values
	localparam logic [7:0] LOWEST_RST  = 8'd255;
	localparam logic [7:0] HIGHEST_RST = 8'd0;

	// pixel mode codes
	localparam logic MODE_MEASURE = 1'b0;
	localparam logic MODE_RECOLOR = 1'b1;

	// channel sequencing: red, green, blue
	localparam logic [1:0] CHAN_RED   = 2'd0;
	localparam logic [1:0] CHAN_GREEN = 2'd1;
	localparam logic [1:0] CHAN_LAST  = 2'd2;

	// scale divider: 16 quotient bits, one per cycle
	localparam int SCALE_W = 16;
	localparam int STEP_W  = $clog2(SCALE_W);
	localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SCALE_W - 1);

	// input request payload
	typedef struct packed {
		logic       mode;
		logic       first_pixel;
		logic [7:0] red_in;
		logic [7:0] green_in;
		logic [7:0] blue_in;
		logic [7:0] alpha_in;
	} pix_t;

	// result payload
	typedef struct packed {
		logic [7:0] red_out;
		logic [7:0] green_out;
		logic [7:0] blue_out;
		logic [7:0] alpha_out;
	} res_t;

endpackage

@@ rtl/core/icon_contrast_remap_unit.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icon_contrast_remap_unit
// Min/max contrast stretch of an RGBA image streamed twice: measure, recolor.
// ----------------------------------------------------------------------------
// measure pixel: no result; skipped as transparent when alpha is present and zero
// recolor pixel: the sequencer holds in its output state while the result is stalled
// recolor result registered in the output state, after the r, g and b channel steps
// first recolor pixel runs the bit-serial scale divider when highest exceeds lowest
// r, g and b go one at a time through a shared compare / multiply unit
// arst_n resets the sequencer, statistics, scale, offset and config registers
module icon_contrast_remap_unit
	import icr_pkg::*;
(
	input  logic                 clk,
	input  logic                 arst_n,
	// pixel requests
	input  logic                 pix_valid,
	output logic                 pix_stall,
	input  pix_t                 pix,
	// results
	output logic                 res_valid,
	input  logic                 res_stall,
	output res_t                 res,
	// configuration writes
	input  logic                 cfg_write,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [7:0]           cfg_data
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_DIV  = 4'b0010,
		S_CHAN = 4'b0100,
		S_OUT  = 4'b1000
	} state_t;

	state_t               state_q;
	pix_t                 item_q;
	logic [7:0]           range_q;
	logic [7:0]           center_q;
	logic                 alpha_en_q;
	logic [7:0]           lowest_q;
	logic [7:0]           highest_q;
	logic [SCALE_W-1:0]   scale_q;
	logic [7:0]           offset_q;
	logic [1:0]           chan_q;
	logic [STEP_W-1:0]    step_q;
	logic [7:0]           rem_q;
	logic [7:0]           divisor_q;
	logic [7:0]           red_q;
	logic [7:0]           green_q;
	logic [7:0]           blue_q;
	logic                 res_valid_q;
	res_t                 res_q;

	logic                 pix_acc;
	logic                 res_free;
	logic [7:0]           chan_val;
	logic [8:0]           diff9;
	logic [15:0]          diff16;
	logic [15:0]          prod;
	logic [7:0]           remapped;
	logic [8:0]           trial;
	logic                 trial_ge;

	assign pix_stall = (state_q != S_IDLE);
	assign pix_acc   = pix_valid && !pix_stall;
	assign res_free  = !res_valid_q || !res_stall;
	assign res_valid = res_valid_q;
	assign res       = res_q;

	// channel select for the shared unit
	always_comb begin
		case (chan_q)
			CHAN_RED:   chan_val = item_q.red_in;
			CHAN_GREEN: chan_val = item_q.green_in;
			default:    chan_val = item_q.blue_in;
		endcase
	end

	// remap: the wrapped difference times scale keeps its low 16 bits; bits 15:8 plus offset
	assign diff9    = {1'b0, chan_val} - {1'b0, lowest_q};
	assign diff16   = {{7{diff9[8]}}, diff9};
	assign prod     = diff16 * scale_q;
	assign remapped = prod[15:8] + offset_q;

	// restoring divider step
	assign trial    = {rem_q, scale_q[SCALE_W-1]};
	assign trial_ge = (trial >= {1'b0, divisor_q});

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q    <= RANGE_WIDTH_RST;
			center_q   <= CENTER_LEVEL_RST;
			alpha_en_q <= ALPHA_PRESENT_RST;
		end else if (cfg_write) begin
			unique case (cfg_index)
				CFG_RANGE_WIDTH:   range_q    <= cfg_data;
				CFG_CENTER_LEVEL:  center_q   <= cfg_data;
				CFG_ALPHA_PRESENT: alpha_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// sequencer, statistics, scale and offset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			lowest_q  <= LOWEST_RST;
			highest_q <= HIGHEST_RST;
			scale_q   <= '0;
			offset_q  <= '0;
			chan_q    <= CHAN_RED;
			step_q    <= '0;
			rem_q     <= '0;
			divisor_q <= '0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					chan_q <= CHAN_RED;
					if (pix_acc) begin
						if (pix.mode == MODE_MEASURE) begin
							if (pix.first_pixel) begin
								lowest_q  <= LOWEST_RST;
								highest_q <= HIGHEST_RST;
							end
							if (!(alpha_en_q && pix.alpha_in == 8'd0)) begin
								state_q <= S_CHAN;
							end
						end else if (pix.first_pixel) begin
							// derive offset now, scale through the divider when highest exceeds lowest
							if (highest_q == lowest_q) begin
								offset_q <= center_q;
							end else begin
								offset_q <= center_q - {1'b0, range_q[7:1]};
							end
							if (highest_q > lowest_q) begin
								scale_q   <= {range_q, 8'd0};
								rem_q     <= '0;
								divisor_q <= highest_q - lowest_q;
								step_q    <= '0;
								state_q   <= S_DIV;
							end else begin
								scale_q <= '0;
								state_q <= S_CHAN;
							end
						end else begin
							state_q <= S_CHAN;
						end
					end
				end
				S_DIV: begin
					// dividend shifts out of scale_q as quotient bits shift in
					if (trial_ge) begin
						rem_q <= 8'(trial - {1'b0, divisor_q});
					end else begin
						rem_q <= trial[7:0];
					end
					scale_q <= {scale_q[SCALE_W-2:0], trial_ge};
					step_q  <= step_q + 1'b1;
					if (step_q == STEP_LAST) begin
						state_q <= S_CHAN;
					end
				end
				S_CHAN: begin
					if (item_q.mode == MODE_MEASURE) begin
						if (chan_val < lowest_q) begin
							lowest_q <= chan_val;
						end
						if (chan_val > highest_q) begin
							highest_q <= chan_val;
						end
					end
					chan_q <= chan_q + 1'b1;
					if (chan_q == CHAN_LAST) begin
						state_q <= (item_q.mode == MODE_MEASURE) ? S_IDLE : S_OUT;
					end
				end
				S_OUT: begin
					if (res_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// request capture and remapped channels
	always_ff @(posedge clk) begin
		if (pix_acc) begin
			item_q <= pix;
		end
		if (state_q == S_CHAN && item_q.mode == MODE_RECOLOR) begin
			case (chan_q)
				CHAN_RED:   red_q   <= remapped;
				CHAN_GREEN: green_q <= remapped;
				default:    blue_q  <= remapped;
			endcase
		end
		if (state_q == S_OUT && res_free) begin
			res_q.red_out   <= red_q;
			res_q.green_out <= green_q;
			res_q.blue_out  <= blue_q;
			res_q.alpha_out <= item_q.alpha_in;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (state_q == S_OUT && res_free) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	// a plain recolor request goes straight to the channel unit
	a_plain_recolor: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_acc && pix.mode == MODE_RECOLOR && !pix.first_pixel) |=> (state_q == S_CHAN))
		else $error("plain recolor request did not enter channel sequence");

	// the divider only runs with a nonzero, unwrapped range
	a_div_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_DIV) |-> (highest_q > lowest_q))
		else $error("divider running with empty or wrapped range");

	// a new result only comes from the output state
	a_res_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(res_valid_q) |-> $past(state_q == S_OUT))
		else $error("result raised outside output state");

	// channel counter stays within r, g, b while sequencing
	a_chan_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CHAN) |-> (chan_q <= CHAN_LAST))
		else $error("channel counter out of range");

endmodule

@@ tb/icon_contrast_remap_unit_tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// icon_contrast_remap_unit_tb
// Streams images through a measure pass and a recolor pass, with random
// gaps, stalls and band settings. A shadow of the min/max stretch predicts
// every recolored pixel, and each result is compared field by field.
// ----------------------------------------------------------------------------
module icon_contrast_remap_unit_tb
	import icr_pkg::*;
();

	localparam int ITEM_TARGET  = 650;
	localparam int DRAIN_CYCLES = 40;
	localparam int CYCLE_LIMIT  = 500000;
	// index 3 decodes to no register
	localparam logic [CFG_IDX_W-1:0] CFG_UNMAPPED = 2'd3;

	// shadow of the stretch datapath and its queue of pending pixels
	class stretch_scoreboard;
		bit [7:0]  band_width;
		bit [7:0]  band_center;
		bit        alpha_gate;
		bit [7:0]  low_seen;
		bit [7:0]  high_seen;
		bit [15:0] gain;
		bit [7:0]  bias;
		res_t      expected_q[$];
		int        fails;

		function new();
			band_width  = RANGE_WIDTH_RST;
			band_center = CENTER_LEVEL_RST;
			alpha_gate  = ALPHA_PRESENT_RST;
			low_seen    = LOWEST_RST;
			high_seen   = HIGHEST_RST;
			gain        = '0;
			bias        = '0;
			fails       = 0;
		endfunction

		function void set_reg(logic [CFG_IDX_W-1:0] idx, bit [7:0] val);
			case (idx)
				CFG_RANGE_WIDTH: begin
					band_width = val;
				end
				CFG_CENTER_LEVEL: begin
					band_center = val;
				end
				CFG_ALPHA_PRESENT: begin
					alpha_gate = val[0];
				end
				default: begin
				end
			endcase
		endfunction

		function bit [7:0] stretch(bit [7:0] c);
			bit [31:0] diff;
			bit [31:0] prod;
			diff = {24'd0, c} - {24'd0, low_seen};
			prod = diff * {16'd0, gain};
			return 8'((prod >> 8) + {24'd0, bias});
		endfunction

		function void track(bit [7:0] c);
			if (c < low_seen)
				low_seen = c;
			if (c > high_seen)
				high_seen = c;
		endfunction

		// note an accepted pixel request, queue its result if any
		function void note_pixel(pix_t p);
			bit [31:0] span;
			res_t      r;
			if (p.mode == MODE_MEASURE) begin
				if (p.first_pixel) begin
					low_seen  = LOWEST_RST;
					high_seen = HIGHEST_RST;
				end
				if (alpha_gate && p.alpha_in == 8'd0)
					return;
				track(p.red_in);
				track(p.green_in);
				track(p.blue_in);
				return;
			end
			// first recolor pixel derives gain and bias from the statistics
			if (p.first_pixel) begin
				span = {24'd0, high_seen} - {24'd0, low_seen};
				if (span != 0) begin
					bias = band_center - (band_width >> 1);
					gain = 16'(({24'd0, band_width} << 8) / span);
				end else begin
					bias = band_center;
					gain = '0;
				end
			end
			r.red_out   = stretch(p.red_in);
			r.green_out = stretch(p.green_in);
			r.blue_out  = stretch(p.blue_in);
			r.alpha_out = p.alpha_in;
			expected_q.push_back(r);
		endfunction

		function void compare_field(string name, bit [7:0] want, bit [7:0] got);
			if (want != got) begin
				$error("%s expected %0d actual %0d", name, want, got);
				fails++;
			end
		endfunction

		function void check_result(res_t got);
			res_t want;
			if (expected_q.size() == 0) begin
				$error("result with nothing pending: %h", got);
				fails++;
				return;
			end
			want = expected_q.pop_front();
			compare_field("red_out", want.red_out, got.red_out);
			compare_field("green_out", want.green_out, got.green_out);
			compare_field("blue_out", want.blue_out, got.blue_out);
			compare_field("alpha_out", want.alpha_out, got.alpha_out);
		endfunction
	endclass

	logic                 clk;
	logic                 arst_n;
	logic                 pix_valid;
	logic                 pix_stall;
	pix_t                 pix;
	logic                 res_valid;
	logic                 res_stall;
	res_t                 res;
	logic                 cfg_write;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [7:0]           cfg_data;

	stretch_scoreboard sb;
	bit                quiet;
	int                items_sent;
	int                cycle_count;

	icon_contrast_remap_unit dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix       (pix),
		.res_valid (res_valid),
		.res_stall (res_stall),
		.res       (res),
		.cfg_write (cfg_write),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// watchdog
	initial cycle_count = 0;
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("icon_contrast_remap_unit regression: fail");
			$finish;
		end
	end

	// result side: check on accept, then draw the next stall
	initial begin : result_sink
		int stall_left;
		stall_left = 0;
		res_stall  = 1'b0;
		forever begin
			@(posedge clk);
			if (res_valid && !res_stall) begin
				sb.check_result(res);
				stall_left = quiet ? 0 : $urandom_range(0, 14);
			end
			@(negedge clk);
			res_stall <= (stall_left != 0);
			if (stall_left != 0)
				stall_left--;
		end
	end

	function automatic pix_t make_pixel(logic mode, logic first, bit [7:0] r, bit [7:0] g,
			bit [7:0] b, bit [7:0] a);
		pix_t p;
		p.mode        = mode;
		p.first_pixel = first;
		p.red_in      = r;
		p.green_in    = g;
		p.blue_in     = b;
		p.alpha_in    = a;
		return p;
	endfunction

	// channels either spread over the full scale or clustered in a band
	function automatic pix_t random_pixel();
		pix_t p;
		int   level;
		int   spread;
		p = pix_t'({$urandom, $urandom});
		if ($urandom_range(0, 1) == 0) begin
			spread     = $urandom_range(0, 40);
			level      = $urandom_range(0, 255 - spread);
			p.red_in   = 8'(level + $urandom_range(0, spread));
			p.green_in = 8'(level + $urandom_range(0, spread));
			p.blue_in  = 8'(level);
		end
		case ($urandom_range(0, 4))
			0: p.alpha_in = 8'd0;
			1: p.alpha_in = 8'd255;
			default: begin
			end
		endcase
		return p;
	endfunction

	function automatic bit [7:0] pick_level();
		case ($urandom_range(0, 4))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd1;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	// one pixel request; entered and left at a falling edge
	task automatic send_pixel(pix_t p);
		int gap;
		gap = quiet ? 0 : $urandom_range(0, 14);
		if (gap != 0) begin
			pix_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		do
			@(posedge clk);
		while (pix_stall);
		sb.note_pixel(p);
		items_sent++;
		@(negedge clk);
	endtask

	// sender pauses until every pending result is back and the block is quiet
	task automatic hold_off();
		pix_valid <= 1'b0;
		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, bit [7:0] val);
		cfg_write <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		sb.set_reg(idx, val);
		@(negedge clk);
		cfg_write <= 1'b0;
		@(negedge clk);
	endtask

	task automatic retune();
		hold_off();
		write_reg(CFG_RANGE_WIDTH, pick_level());
		write_reg(CFG_CENTER_LEVEL, pick_level());
		write_reg(CFG_ALPHA_PRESENT, 8'($urandom_range(0, 1)));
		if ($urandom_range(0, 9) == 0)
			write_reg(CFG_UNMAPPED, 8'($urandom_range(0, 255)));
	endtask

	// measure pass then recolor pass; a few images get scrambled flags
	task automatic run_image();
		int   n;
		bit   broken;
		pix_t p;
		n      = ($urandom_range(0, 9) == 0) ? $urandom_range(13, 40) : $urandom_range(1, 8);
		broken = ($urandom_range(0, 7) == 0);
		quiet  = ($urandom_range(0, 4) == 0);
		for (int pass = 0; pass < 2; pass++) begin
			for (int i = 0; i < n; i++) begin
				p             = random_pixel();
				p.mode        = (pass == 0) ? MODE_MEASURE : MODE_RECOLOR;
				p.first_pixel = (i == 0);
				if (broken) begin
					p.mode        = logic'($urandom_range(0, 1));
					p.first_pixel = logic'($urandom_range(0, 1));
				end
				send_pixel(p);
			end
		end
		if ($urandom_range(0, 7) == 0)
			hold_off();
	endtask

	// stimulus
	initial begin
		sb         = new();
		quiet      = 1'b0;
		items_sent = 0;
		arst_n     = 1'b0;
		pix_valid  = 1'b0;
		pix        = '0;
		cfg_write  = 1'b0;
		cfg_index  = CFG_RANGE_WIDTH;
		cfg_data   = 8'd0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// recolor before any derivation, then derive from reset statistics
		send_pixel(make_pixel(MODE_RECOLOR, 1'b0, 8'd255, 8'd0, 8'd128, 8'd77));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b1, 8'd255, 8'd0, 8'd1, 8'd0));
		hold_off();
		write_reg(CFG_RANGE_WIDTH, 8'd255);
		write_reg(CFG_CENTER_LEVEL, 8'd128);
		write_reg(CFG_ALPHA_PRESENT, 8'd1);
		// empty measure pass: only a transparent pixel
		send_pixel(make_pixel(MODE_MEASURE, 1'b1, 8'd0, 8'd255, 8'd9, 8'd0));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b1, 8'd10, 8'd200, 8'd255, 8'd255));
		// narrow band, transparent pixel skipped, channels below the minimum
		send_pixel(make_pixel(MODE_MEASURE, 1'b1, 8'd100, 8'd150, 8'd120, 8'd255));
		send_pixel(make_pixel(MODE_MEASURE, 1'b0, 8'd0, 8'd0, 8'd0, 8'd0));
		send_pixel(make_pixel(MODE_MEASURE, 1'b0, 8'd140, 8'd110, 8'd130, 8'd1));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b1, 8'd100, 8'd150, 8'd125, 8'd200));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b0, 8'd0, 8'd255, 8'd99, 8'd0));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b0, 8'd255, 8'd255, 8'd255, 8'd255));
		hold_off();
		write_reg(CFG_ALPHA_PRESENT, 8'd0);
		write_reg(CFG_RANGE_WIDTH, 8'd200);
		write_reg(CFG_CENTER_LEVEL, 8'd0);
		write_reg(CFG_UNMAPPED, 8'd255);
		// flat image: zero span, alpha ignored
		send_pixel(make_pixel(MODE_MEASURE, 1'b1, 8'd50, 8'd50, 8'd50, 8'd0));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b1, 8'd50, 8'd0, 8'd255, 8'd10));
		// full span with a wrapping bias
		send_pixel(make_pixel(MODE_MEASURE, 1'b1, 8'd0, 8'd255, 8'd7, 8'd255));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b1, 8'd0, 8'd255, 8'd128, 8'd128));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b0, 8'd85, 8'd170, 8'd254, 8'd170));
		// restart mid pass drops the earlier statistics
		send_pixel(make_pixel(MODE_MEASURE, 1'b1, 8'd0, 8'd255, 8'd0, 8'd9));
		send_pixel(make_pixel(MODE_MEASURE, 1'b1, 8'd60, 8'd61, 8'd62, 8'd9));
		send_pixel(make_pixel(MODE_RECOLOR, 1'b1, 8'd60, 8'd62, 8'd255, 8'd33));
		hold_off();
		write_reg(CFG_ALPHA_PRESENT, 8'd1);
		write_reg(CFG_CENTER_LEVEL, 8'd255);

		// random images
		while (items_sent < ITEM_TARGET) begin
			if ($urandom_range(0, 2) == 0)
				retune();
			run_image();
		end
		quiet = 1'b0;
		pix_valid <= 1'b0;

		while (sb.expected_q.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.fails == 0)
			$display("icon_contrast_remap_unit regression: pass");
		else
			$display("icon_contrast_remap_unit regression: fail");
		$finish;
	end

endmodule
